// ===== rtl/core/bske_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bske_pkg
// Shared constants, codes and types of the beta-skeleton edge test block.
// ----------------------------------------------------------------------------
package bske_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int DIST_BITS    = 16;

  localparam int VTX_W    = $clog2(MAX_VERTICES);
  localparam int COUNT_W  = VTX_W + 1;
  localparam int ADDR_W   = 2 * VTX_W;
  localparam int COEF_W   = 17;
  localparam int COEF_FRAC = 14;
  localparam int SQ_W     = 2 * DIST_BITS;
  localparam int SCALED_W = SQ_W + 1 + COEF_FRAC;
  localparam int PROD_W   = COEF_W + SQ_W + 1;
  localparam int ACC_W    = PROD_W + 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [COUNT_W-1:0] VTX_LIMIT = COUNT_W'(MAX_VERTICES);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_BELOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_COEF    = 2'd2;

  typedef struct packed {
    logic                     lune;
    logic signed [COEF_W-1:0] coef;
  } eval_cfg_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } eval_status_t;

endpackage

// ===== rtl/core/bske_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bske_mem
// Distance matrix store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bske_mem (
  input  logic                            clk,
  input  logic                            we,
  input  logic [bske_pkg::ADDR_W-1:0]     waddr,
  input  logic [bske_pkg::DIST_BITS-1:0]  wdata,
  input  logic [bske_pkg::ADDR_W-1:0]     raddr_a,
  input  logic [bske_pkg::ADDR_W-1:0]     raddr_b,
  output logic [bske_pkg::DIST_BITS-1:0]  rdata_a,
  output logic [bske_pkg::DIST_BITS-1:0]  rdata_b
);
  import bske_pkg::*;

  logic [DIST_BITS-1:0] mem [0:(1 << ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/core/bske_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bske_eval
// Per-vertex rejection pipeline: squares, coefficient products, exact compare.
// ----------------------------------------------------------------------------
module bske_eval (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            issue_valid,
  input  bske_pkg::eval_cfg_t             cfg,
  input  logic [bske_pkg::SQ_W-1:0]       dij_sq,
  input  logic [bske_pkg::DIST_BITS-1:0]  dik,
  input  logic [bske_pkg::DIST_BITS-1:0]  djk,
  output bske_pkg::eval_status_t          status
);
  import bske_pkg::*;

  logic va, vb, vc, vd;
  logic [SQ_W-1:0] pik2, pjk2, pxy;
  logic [SQ_W-1:0] pik2_c, pjk2_c;
  logic signed [PROD_W-1:0] m1, m2;
  logic rej;

  logic [SQ_W-1:0]  sel1;
  logic [SQ_W:0]    term1;
  logic signed [ACC_W-1:0] sij_s, t1_s, t2_s, m1_s, m2_s, diff1, diff2;
  logic gt1, gt2;

  always_comb begin
    sel1  = cfg.lune ? pxy : pik2;
    term1 = cfg.lune ? ({1'b0, pik2_c} + {1'b0, pjk2_c}) : {1'b0, pjk2_c};
    sij_s = $signed({{(ACC_W-SQ_W-COEF_FRAC){1'b0}}, dij_sq, {COEF_FRAC{1'b0}}});
    t1_s  = $signed({{(ACC_W-SQ_W-1-COEF_FRAC){1'b0}}, term1, {COEF_FRAC{1'b0}}});
    t2_s  = $signed({{(ACC_W-SQ_W-COEF_FRAC){1'b0}}, pik2_c, {COEF_FRAC{1'b0}}});
    m1_s  = {{(ACC_W-PROD_W){m1[PROD_W-1]}}, m1};
    m2_s  = {{(ACC_W-PROD_W){m2[PROD_W-1]}}, m2};
    diff1 = sij_s - t1_s - m1_s;
    diff2 = sij_s - t2_s - m2_s;
    gt1   = !diff1[ACC_W-1] && (diff1 != '0);
    gt2   = !diff2[ACC_W-1] && (diff2 != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= issue_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    pik2   <= dik * dik;
    pjk2   <= djk * djk;
    pxy    <= dik * djk;
    m1     <= cfg.coef * $signed({1'b0, sel1});
    m2     <= cfg.coef * $signed({1'b0, pjk2});
    pik2_c <= pik2;
    pjk2_c <= pjk2;
    rej    <= cfg.lune ? gt1 : (gt1 && gt2);
  end

  assign status.busy = va | vb | vc | vd;
  assign status.hit  = vd & rej;

endmodule

// ===== rtl/core/beta_skeleton_edge_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beta_skeleton_edge_test
// Beta-skeleton edge test over a distance matrix held in on-chip memory.
// ----------------------------------------------------------------------------
// A write transaction (op 0) stores one Q8.8 distance in the memory; it
// gives no result. A test transaction (op 1) reads dij, then walks vertices k
// below min(vertex_count, 64), reading dik and djk through the two read ports
// of the distance memory, one k per cycle, into a four-stage compare pipeline.
// A new transaction is accepted as soon as the result sits in the output
// register. The memory is not cleared at reset: every entry a test reads must
// be written beforehand. Configuration writes are accepted at any time and
// must only be made while the block is idle.
module beta_skeleton_edge_test (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [bske_pkg::VTX_W-1:0]        row_index,
  input  logic [bske_pkg::VTX_W-1:0]        col_index,
  input  logic [bske_pkg::DIST_BITS-1:0]    distance,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              edge_kept,
  output logic [bske_pkg::VTX_W-1:0]        first_vertex,
  output logic [bske_pkg::VTX_W-1:0]        second_vertex,
  output logic [bske_pkg::DIST_BITS-1:0]    pair_distance,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bske_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bske_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bske_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIJ    = 3'd1;
  localparam logic [2:0] S_SQ     = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [COUNT_W-1:0] vertex_count;
  eval_cfg_t cfg;
  logic [VTX_W-1:0] row, col;
  logic [COUNT_W-1:0] k;
  logic [DIST_BITS-1:0] dij;
  logic [SQ_W-1:0] dij_sq;
  logic kept;

  logic [COUNT_W-1:0] limit;
  logic [COUNT_W:0] k_inc;
  logic walk_last;
  logic issue_valid;
  logic mem_we;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [DIST_BITS-1:0] rdata_a, rdata_b;
  eval_status_t status;
  logic out_load;

  assign limit     = (vertex_count > VTX_LIMIT) ? VTX_LIMIT : vertex_count;
  assign k_inc     = {1'b0, k} + 1'b1;
  assign walk_last = k_inc >= {1'b0, limit};
  assign issue_valid = (state == S_WALK) && (k < limit)
                       && (k[VTX_W-1:0] != row) && (k[VTX_W-1:0] != col);

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mem_we    = in_valid && in_ready && (op == OP_WRITE);
  assign raddr_a   = (state == S_DIJ) ? {row, col} : {row, k[VTX_W-1:0]};
  assign raddr_b   = {col, k[VTX_W-1:0]};
  assign out_load  = (state == S_FINISH) && (!out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VTX_LIMIT;
      cfg.lune     <= 1'b1;
      cfg.coef     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT: vertex_count <= cfg_data[COUNT_W-1:0];
        CFG_BETA_BELOW:   cfg.lune     <= cfg_data[0];
        CFG_BETA_COEF:    cfg.coef     <= $signed(cfg_data[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      kept  <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && op == OP_TEST) begin
            state <= S_DIJ;
          end
        end
        S_DIJ: begin
          state <= S_SQ;
        end
        S_SQ: begin
          k     <= '0;
          kept  <= 1'b1;
          state <= S_WALK;
        end
        S_WALK: begin
          k <= k_inc[COUNT_W-1:0];
          if (walk_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!status.busy) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (status.hit) begin
        kept <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      row <= row_index;
      col <= col_index;
    end
    if (state == S_SQ) begin
      dij    <= rdata_a;
      dij_sq <= rdata_a * rdata_a;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      edge_kept     <= kept;
      first_vertex  <= row;
      second_vertex <= col;
      pair_distance <= dij;
    end
  end

  bske_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   ({row_index, col_index}),
    .wdata   (distance),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  bske_eval u_eval (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (issue_valid),
    .cfg         (cfg),
    .dij_sq      (dij_sq),
    .dik         (rdata_a),
    .djk         (rdata_b),
    .status      (status)
  );

endmodule

// ===== rtl/core/bske_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bske_check
// Port-level checks of the beta-skeleton edge test block, bound to its top.
// ----------------------------------------------------------------------------
module bske_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              op,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              edge_kept,
  input logic [bske_pkg::VTX_W-1:0]        first_vertex,
  input logic [bske_pkg::VTX_W-1:0]        second_vertex,
  input logic [bske_pkg::DIST_BITS-1:0]    pair_distance
);
  import bske_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(edge_kept)
      && $stable(first_vertex) && $stable(second_vertex) && $stable(pair_distance))
    else $error("stalled result changed");

  // a write transaction completes at once
  a_write_done: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_WRITE |=> in_ready)
    else $error("input stalled after a write transaction");

  // input readiness drops after a test transaction is accepted, and no result rises with it
  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_TEST |=> !in_ready && !$rose(out_valid))
    else $error("input taken while a test runs");

  // a new result appears together with input readiness
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result issued while busy");

endmodule

bind beta_skeleton_edge_test bske_check u_check (.*);

// ===== sim/bske_edge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bske_edge_checker
// Watches the write, test, result and register channels of the beta-skeleton
// edge test block, keeps its own copy of the distance matrix and registers,
// works out the keep flag of every pair test with exact wide arithmetic and
// compares each result transaction with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bske_edge_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              op,
  input  logic [bske_pkg::VTX_W-1:0]        row_index,
  input  logic [bske_pkg::VTX_W-1:0]        col_index,
  input  logic [bske_pkg::DIST_BITS-1:0]    distance,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              edge_kept,
  input  logic [bske_pkg::VTX_W-1:0]        first_vertex,
  input  logic [bske_pkg::VTX_W-1:0]        second_vertex,
  input  logic [bske_pkg::DIST_BITS-1:0]    pair_distance,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bske_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bske_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                failures,
  output int                                pending
);
  import bske_pkg::*;

  typedef struct packed {
    logic                 kept;
    logic [VTX_W-1:0]     vi;
    logic [VTX_W-1:0]     vj;
    logic [DIST_BITS-1:0] dij;
  } edge_result_t;

  edge_result_t               awaited_q[$];
  logic [DIST_BITS-1:0]       dist_mem [0:MAX_VERTICES*MAX_VERTICES-1];
  logic [COUNT_W-1:0]         vcount;
  logic                       lune_form;
  logic signed [COEF_W-1:0]   coef;
  int                         fail_count = 0;
  int                         awaited_n = 0;

  assign failures = fail_count;
  assign pending  = awaited_n;

  // squared distance scaled to the Q3.14 coefficient
  function automatic logic signed [127:0] scaled_sq(input logic signed [127:0] d);
    return d * d * 16384;
  endfunction

  function automatic logic pair_survives(input logic [VTX_W-1:0] vi,
                                         input logic [VTX_W-1:0] vj);
    int lim;
    int k;
    logic signed [127:0] cw, dij, dik, djk, sij;
    logic hit;
    lim = (vcount < VTX_LIMIT) ? int'(vcount) : MAX_VERTICES;
    cw  = coef;
    dij = dist_mem[{vi, vj}];
    sij = scaled_sq(dij);
    for (k = 0; k < lim; k++) begin
      if (k != vi && k != vj) begin
        dik = dist_mem[{vi, VTX_W'(k)}];
        djk = dist_mem[{vj, VTX_W'(k)}];
        if (lune_form) begin
          hit = sij > scaled_sq(dik) + scaled_sq(djk) + cw * dik * djk;
        end else begin
          hit = (sij > scaled_sq(djk) + cw * dik * dik) &&
                (sij > scaled_sq(dik) + cw * djk * djk);
        end
        if (hit) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    edge_result_t want;
    edge_result_t got;
    if (rst) begin
      vcount    = VTX_LIMIT;
      lune_form = 1'b1;
      coef      = '0;
      awaited_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VERTEX_COUNT: vcount = cfg_data[COUNT_W-1:0];
          CFG_BETA_BELOW:   lune_form = cfg_data[0];
          CFG_BETA_COEF:    coef = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (op == OP_WRITE) begin
          dist_mem[{row_index, col_index}] = distance;
        end else begin
          want.kept = pair_survives(row_index, col_index);
          want.vi   = row_index;
          want.vj   = col_index;
          want.dij  = dist_mem[{row_index, col_index}];
          awaited_q.insert(awaited_q.size(), want);
        end
      end
      if (out_valid && out_ready) begin
        got = {edge_kept, first_vertex, second_vertex, pair_distance};
        if (awaited_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: result transaction with nothing expected, %s",
                   $time, $sformatf("actual kept=%0d i=%0d j=%0d d=%h",
                                    got.kept, got.vi, got.vj, got.dij));
        end else begin
          want = awaited_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t ns: expected kept=%0d i=%0d j=%0d d=%h, %s",
                     $time, want.kept, want.vi, want.vj, want.dij,
                     $sformatf("actual kept=%0d i=%0d j=%0d d=%h",
                               got.kept, got.vi, got.vj, got.dij));
          end
        end
      end
    end
    awaited_n = awaited_q.size();
  end

endmodule

// ===== sim/tb_beta_skeleton_edge_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_beta_skeleton_edge_test
// Loads distance matrices built from random point sets plus noise entries,
// tests vertex pairs under a range of vertex counts, lune and max forms and
// coefficients, with random idle bursts on both channels; the checker beside
// the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_beta_skeleton_edge_test;
  import bske_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = MAX_VERTICES + 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   op;
  logic [VTX_W-1:0]       row_index;
  logic [VTX_W-1:0]       col_index;
  logic [DIST_BITS-1:0]   distance;
  logic                   out_valid;
  logic                   out_ready;
  logic                   edge_kept;
  logic [VTX_W-1:0]       first_vertex;
  logic [VTX_W-1:0]       second_vertex;
  logic [DIST_BITS-1:0]   pair_distance;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int failures;
  int pending;
  int cycles = 0;
  int phase_items = 0;
  bit in_idle_en = 1'b1;
  bit out_stall_en = 1'b1;
  int px [MAX_VERTICES];
  int py [MAX_VERTICES];
  bit loaded [MAX_VERTICES][MAX_VERTICES];

  beta_skeleton_edge_test dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .row_index(row_index), .col_index(col_index), .distance(distance),
    .out_valid(out_valid), .out_ready(out_ready),
    .edge_kept(edge_kept), .first_vertex(first_vertex),
    .second_vertex(second_vertex), .pair_distance(pair_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bske_edge_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .row_index(row_index), .col_index(col_index), .distance(distance),
    .out_valid(out_valid), .out_ready(out_ready),
    .edge_kept(edge_kept), .first_vertex(first_vertex),
    .second_vertex(second_vertex), .pair_distance(pair_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("beta_skeleton_edge_test: mismatch");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_stall_en && $urandom_range(0, 99) < 10) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void scatter_points();
    int v;
    int spread;
    spread = $urandom_range(8, 180);
    for (v = 0; v < MAX_VERTICES; v++) begin
      px[v] = $urandom_range(0, spread);
      py[v] = $urandom_range(0, spread);
    end
  endfunction

  function automatic logic [DIST_BITS-1:0] geo_dist(input int a, input int b);
    real dx, dy, d;
    dx = px[a] - px[b];
    dy = py[a] - py[b];
    d  = $sqrt(dx * dx + dy * dy) * 256.0 + 0.5;
    if (d >= 65535.0) begin
      return '1;
    end
    return DIST_BITS'($rtoi(d));
  endfunction

  function automatic logic [DIST_BITS-1:0] noise_dist();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return DIST_BITS'($urandom);
    endcase
  endfunction

  function automatic int pool_vertex(input int lim);
    int v;
    if (lim < 2 || $urandom_range(0, 99) < 12) begin
      return $urandom_range(0, MAX_VERTICES - 1);
    end
    if (lim > 16) begin
      v = $urandom_range(0, 6);
      return (v == 6) ? MAX_VERTICES - 1 : v;
    end
    return $urandom_range(0, lim - 1);
  endfunction

  task automatic send_item(input logic o, input logic [VTX_W-1:0] r,
                           input logic [VTX_W-1:0] c, input logic [DIST_BITS-1:0] d);
    if (in_idle_en && $urandom_range(0, 99) < 12) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    op        <= o;
    row_index <= r;
    col_index <= c;
    distance  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    phase_items++;
  endtask

  task automatic write_entry(input int r, input int c, input logic [DIST_BITS-1:0] d);
    send_item(OP_WRITE, VTX_W'(r), VTX_W'(c), d);
    loaded[r][c] = 1'b1;
  endtask

  // every entry the walk may touch is written before the pair is tested
  task automatic test_pair(input int r, input int c, input int lim_load);
    int k;
    for (k = 0; k < lim_load; k++) begin
      if (!loaded[r][k]) write_entry(r, k, geo_dist(r, k));
      if (!loaded[c][k]) write_entry(c, k, geo_dist(c, k));
    end
    if (!loaded[r][c]) write_entry(r, c, geo_dist(r, c));
    send_item(OP_TEST, VTX_W'(r), VTX_W'(c), DIST_BITS'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] vc, input logic lune,
                           input logic [COEF_W-1:0] cf, input int budget, input bit quiet);
    int lim, lim_load, r, c, roll;
    drain_block();
    in_idle_en   = !quiet && $urandom_range(0, 3) != 0;
    out_stall_en = !quiet && $urandom_range(0, 3) != 0;
    write_reg(CFG_VERTEX_COUNT, CFG_DATA_W'(vc));
    write_reg(CFG_BETA_BELOW, CFG_DATA_W'(lune));
    write_reg(CFG_BETA_COEF, cf);
    lim      = (vc < VTX_LIMIT) ? int'(vc) : MAX_VERTICES;
    lim_load = (lim < MAX_VERTICES) ? lim + 1 : MAX_VERTICES;
    if (lim_load < 2) lim_load = 2;
    phase_items = 0;
    if (lim <= 16) begin
      scatter_points();
      for (r = 0; r < lim_load; r++) begin
        for (c = 0; c < lim_load; c++) begin
          write_entry(r, c, geo_dist(r, c));
        end
      end
    end
    while (phase_items < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        r = pool_vertex(lim);
        c = pool_vertex(lim);
        test_pair(r, c, lim_load);
      end else if (roll < 88) begin
        r = pool_vertex(lim);
        c = $urandom_range(0, lim_load - 1);
        write_entry(r, c, ($urandom_range(0, 1) != 0) ? noise_dist() : geo_dist(r, c));
      end else begin
        write_entry($urandom_range(0, MAX_VERTICES - 1), $urandom_range(0, MAX_VERTICES - 1),
                    noise_dist());
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = OP_WRITE;
    row_index = '0;
    col_index = '0;
    distance  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_VERTEX_COUNT;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: three vertices with extreme distances, a far vertex outside the count
    scatter_points();
    write_reg(CFG_VERTEX_COUNT, CFG_DATA_W'(3));
    write_reg(CFG_BETA_BELOW, CFG_DATA_W'(1));
    write_reg(CFG_BETA_COEF, CFG_DATA_W'(28378));
    write_reg(CFG_UNUSED, '1);
    write_entry(0, 0, '0);
    write_entry(1, 1, '0);
    write_entry(2, 2, '0);
    write_entry(0, 1, '1);
    write_entry(1, 0, '1);
    write_entry(0, 2, 16'h0001);
    write_entry(2, 0, 16'h0001);
    write_entry(1, 2, 16'h8000);
    write_entry(2, 1, 16'h8000);
    write_entry(63, 0, 16'h7fff);
    write_entry(63, 1, 16'h0100);
    write_entry(63, 2, 16'hc3a5);
    write_entry(0, 63, 16'h7fff);
    test_pair(0, 1, 4);
    test_pair(1, 2, 4);
    test_pair(0, 2, 4);
    test_pair(1, 1, 4);
    test_pair(63, 0, 4);
    test_pair(0, 63, 4);

    run_phase(7'd2, 1'b1, COEF_W'(28378), 90, 1'b0);
    run_phase(7'd3, 1'b0, COEF_W'(16384), 90, 1'b0);
    run_phase(7'd8, 1'b1, '0, 150, 1'b0);
    run_phase(7'd12, 1'b0, COEF_W'(-16384), 170, 1'b0);
    run_phase(7'd64, 1'b1, COEF_W'(32768), 260, 1'b0);
    run_phase(7'd127, 1'b0, COEF_W'(8192), 140, 1'b0);
    run_phase(7'd0, 1'b1, COEF_W'($urandom), 40, 1'b0);
    run_phase(7'd1, 1'b0, COEF_W'($urandom), 40, 1'b0);
    run_phase(7'd5, 1'b1, COEF_W'(-65536), 100, 1'b0);
    run_phase(COUNT_W'($urandom_range(2, 16)), 1'($urandom_range(0, 1)),
              COEF_W'(65535), 120, 1'b0);
    run_phase(COUNT_W'($urandom_range(2, 64)), 1'($urandom_range(0, 1)),
              COEF_W'($urandom_range(0, 49152) - 16384), 150, 1'b0);
    run_phase(7'd6, 1'b1, COEF_W'(23170), 300, 1'b1);

    drain_block();
    if (failures == 0 && pending == 0) begin
      $display("beta_skeleton_edge_test: match");
    end else begin
      $display("beta_skeleton_edge_test: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bske_pkg.sv
rtl/core/bske_mem.sv
rtl/core/bske_eval.sv
rtl/core/beta_skeleton_edge_test.sv
rtl/core/bske_check.sv
sim/bske_edge_checker.sv
sim/tb_beta_skeleton_edge_test.sv
